@@ rtl/core/cvh_pkg.sv @@
// cvh_pkg: shared types and codes for the convex hull block
// command and status structs between controller and datapath
// no dependencies
package cvh_pkg;

	// operand A load source
	typedef logic [1:0] asel_t;
	localparam asel_t A_HOLD = 2'd0;
	localparam asel_t A_PT   = 2'd1;
	localparam asel_t A_ANC  = 2'd2;
	localparam asel_t A_B    = 2'd3;

	// operand B load source
	typedef logic [1:0] bsel_t;
	localparam bsel_t B_HOLD = 2'd0;
	localparam bsel_t B_PT   = 2'd1;
	localparam bsel_t B_A    = 2'd2;
	localparam bsel_t B_C    = 2'd3;

	typedef struct packed {
		logic  pt_we;
		logic  anc_first;
		logic  so_we;
		logic  st_we;
		asel_t a_sel;
		bsel_t b_sel;
		logic  c_ld;
		logic  geo_dist;
		logic  out_load;
		logic  out_hv;
		logic  out_last;
		logic  out_ovf;
	} cmd_t;

	typedef struct packed {
		logic geo_zero;
		logic geo_neg;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/cvh_ram.sv @@
// cvh_ram: generic single write port, single read port ram
// read data registered; no dependencies
module cvh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/cvh_dp.sv @@
// cvh_dp: datapath of the convex hull block
// point, order and stack memories, anchor tracking, geometry unit, output register
// uses cvh_pkg and cvh_ram
module cvh_dp #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cvh_pkg::cmd_t                 cmd,
	input  logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
	input  logic                          so_we_dummy_n,
	input  logic [$clog2(MAX_POINTS)-1:0] so_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0] so_wdata,
	input  logic [$clog2(MAX_POINTS)-1:0] so_raddr,
	input  logic [$clog2(MAX_POINTS)-1:0] st_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0] st_wdata,
	input  logic [$clog2(MAX_POINTS)-1:0] st_raddr,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [COORD_BITS-1:0]  hull_x,
	output logic signed [COORD_BITS-1:0]  hull_y,
	output logic                          hull_valid,
	output logic                          overflowed,
	output logic                          last_vertex,
	output cvh_pkg::stat_t                stat,
	output logic [$clog2(MAX_POINTS)-1:0] anchor_idx,
	output logic [$clog2(MAX_POINTS)-1:0] so_rdata,
	output logic [$clog2(MAX_POINTS)-1:0] st_rdata
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int W  = COORD_BITS;
	localparam int PW = 2 * W + 4;

	logic [W-1:0] rx_raw, ry_raw;
	logic signed [W-1:0] rx, ry;

	logic signed [W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [W-1:0] anc_x_q, anc_y_q;
	logic [IW-1:0] anc_idx_q;

	logic signed [W+1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
	logic signed [W+1:0] u1, v1, u2, v2;
	logic signed [PW-1:0] m1_d, m2_d, m1_s1, m2_s1;
	logic dist_s1;
	logic signed [PW:0] sum_d;
	logic zero_s2, neg_s2;

	logic out_full_q;
	logic [W-1:0] out_x_q, out_y_q;
	logic out_hv_q, out_ovf_q, out_last_q;

	cvh_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_pt_x (
		.clk(clk), .we(cmd.pt_we), .waddr(pt_waddr), .wdata(point_x),
		.raddr(pt_raddr), .rdata(rx_raw)
	);
	cvh_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_pt_y (
		.clk(clk), .we(cmd.pt_we), .waddr(pt_waddr), .wdata(point_y),
		.raddr(pt_raddr), .rdata(ry_raw)
	);
	cvh_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_order (
		.clk(clk), .we(cmd.so_we & so_we_dummy_n), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(so_rdata)
	);
	cvh_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_stack (
		.clk(clk), .we(cmd.st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	assign rx = $signed(rx_raw);
	assign ry = $signed(ry_raw);

	// anchor: lowest y, then lowest x, tracked while points load
	always_ff @(posedge clk) begin
		if (cmd.pt_we && (cmd.anc_first || (point_y < anc_y_q) ||
				((point_y == anc_y_q) && (point_x < anc_x_q)))) begin
			anc_x_q   <= point_x;
			anc_y_q   <= point_y;
			anc_idx_q <= pt_waddr;
		end
	end
	assign anchor_idx = anc_idx_q;

	// geometry operands
	always_ff @(posedge clk) begin
		case (cmd.a_sel)
			cvh_pkg::A_PT: begin
				ax_q <= rx;
				ay_q <= ry;
			end
			cvh_pkg::A_ANC: begin
				ax_q <= anc_x_q;
				ay_q <= anc_y_q;
			end
			cvh_pkg::A_B: begin
				ax_q <= bx_q;
				ay_q <= by_q;
			end
			default: begin
			end
		endcase
		case (cmd.b_sel)
			cvh_pkg::B_PT: begin
				bx_q <= rx;
				by_q <= ry;
			end
			cvh_pkg::B_A: begin
				bx_q <= ax_q;
				by_q <= ay_q;
			end
			cvh_pkg::B_C: begin
				bx_q <= cx_q;
				by_q <= cy_q;
			end
			default: begin
			end
		endcase
		if (cmd.c_ld) begin
			cx_q <= rx;
			cy_q <= ry;
		end
	end

	assign ax_e = {{2{ax_q[W-1]}}, ax_q};
	assign ay_e = {{2{ay_q[W-1]}}, ay_q};
	assign bx_e = {{2{bx_q[W-1]}}, bx_q};
	assign by_e = {{2{by_q[W-1]}}, by_q};
	assign cx_e = {{2{cx_q[W-1]}}, cx_q};
	assign cy_e = {{2{cy_q[W-1]}}, cy_q};

	// turn: (by-ay)(cx-bx) - (bx-ax)(cy-by)
	// dist: |c-a|^2 - |b-a|^2 = (cx-bx)(cx+bx-2ax) + (cy-by)(cy+by-2ay)
	always_comb begin
		if (cmd.geo_dist) begin
			u1 = cx_e - bx_e;
			v1 = cx_e + bx_e - (ax_e <<< 1);
			u2 = cy_e - by_e;
			v2 = cy_e + by_e - (ay_e <<< 1);
		end else begin
			u1 = by_e - ay_e;
			v1 = cx_e - bx_e;
			u2 = bx_e - ax_e;
			v2 = cy_e - by_e;
		end
	end

	assign m1_d  = PW'(u1) * PW'(v1);
	assign m2_d  = PW'(u2) * PW'(v2);
	assign sum_d = dist_s1 ? ((PW+1)'(m1_s1) + (PW+1)'(m2_s1)) :
		((PW+1)'(m1_s1) - (PW+1)'(m2_s1));

	always_ff @(posedge clk) begin
		m1_s1   <= m1_d;
		m2_s1   <= m2_d;
		dist_s1 <= cmd.geo_dist;
		zero_s2 <= (sum_d == '0);
		neg_s2  <= sum_d[PW];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q    <= cmd.out_hv ? rx_raw : '0;
			out_y_q    <= cmd.out_hv ? ry_raw : '0;
			out_hv_q   <= cmd.out_hv;
			out_ovf_q  <= cmd.out_ovf;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid   = out_full_q;
	assign hull_x      = $signed(out_x_q);
	assign hull_y      = $signed(out_y_q);
	assign hull_valid  = out_hv_q;
	assign overflowed  = out_ovf_q;
	assign last_vertex = out_last_q;

	assign stat.geo_zero = zero_s2;
	assign stat.geo_neg  = neg_s2;
	assign stat.out_free = !out_full_q || out_ready;

endmodule

@@ rtl/core/cvh_ctrl.sv @@
// cvh_ctrl: controller of the convex hull block
// load, angular sort, collinear pruning, stack scan and emit sequencing
// uses cvh_pkg
module cvh_ctrl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          last_point,
	input  cvh_pkg::stat_t                stat,
	input  logic [$clog2(MAX_POINTS)-1:0] anchor_idx,
	input  logic [$clog2(MAX_POINTS)-1:0] so_rdata,
	input  logic [$clog2(MAX_POINTS)-1:0] st_rdata,
	output cvh_pkg::cmd_t                 cmd,
	output logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
	output logic [$clog2(MAX_POINTS)-1:0] so_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] so_wdata,
	output logic [$clog2(MAX_POINTS)-1:0] so_raddr,
	output logic [$clog2(MAX_POINTS)-1:0] st_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] st_wdata,
	output logic [$clog2(MAX_POINTS)-1:0] st_raddr
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [4:0] S_LOAD    = 5'd0;
	localparam logic [4:0] S_SINIT   = 5'd1;
	localparam logic [4:0] S_SI      = 5'd2;
	localparam logic [4:0] S_SI_RD   = 5'd3;
	localparam logic [4:0] S_SJ      = 5'd4;
	localparam logic [4:0] S_SJ_R1   = 5'd5;
	localparam logic [4:0] S_SJ_R2   = 5'd6;
	localparam logic [4:0] S_SJ_CK   = 5'd7;
	localparam logic [4:0] S_GEO1    = 5'd8;
	localparam logic [4:0] S_GEO2    = 5'd9;
	localparam logic [4:0] S_PR_INIT = 5'd10;
	localparam logic [4:0] S_PR_R1   = 5'd11;
	localparam logic [4:0] S_PR_R2   = 5'd12;
	localparam logic [4:0] S_PR_LP   = 5'd13;
	localparam logic [4:0] S_PR_N1   = 5'd14;
	localparam logic [4:0] S_PR_N2   = 5'd15;
	localparam logic [4:0] S_PR_CK   = 5'd16;
	localparam logic [4:0] S_PR_END  = 5'd17;
	localparam logic [4:0] S_SC_INIT = 5'd18;
	localparam logic [4:0] S_SC_0A   = 5'd19;
	localparam logic [4:0] S_SC_0B   = 5'd20;
	localparam logic [4:0] S_SC_0C   = 5'd21;
	localparam logic [4:0] S_SC_LP   = 5'd22;
	localparam logic [4:0] S_SC_R1   = 5'd23;
	localparam logic [4:0] S_SC_R2   = 5'd24;
	localparam logic [4:0] S_SC_CK   = 5'd25;
	localparam logic [4:0] S_SC_P1   = 5'd26;
	localparam logic [4:0] S_SC_P2   = 5'd27;
	localparam logic [4:0] S_EM_RD   = 5'd28;
	localparam logic [4:0] S_EM_R1   = 5'd29;
	localparam logic [4:0] S_EM_R2   = 5'd30;
	localparam logic [4:0] S_EMPTY   = 5'd31;

	logic [4:0] state_q, ret_q;
	logic dist_q, ovf_q;
	logic [CW-1:0] n_q, i_q, j_q, m_q, kept_q, sd_q;
	logic [IW-1:0] a_idx_q, b_idx_q, c_idx_q;

	logic [CW-1:0] i_inc, j_dec, sd_dec, sd_m3;
	logic room, after;

	assign i_inc  = i_q + CW'(1);
	assign j_dec  = j_q - CW'(1);
	assign sd_dec = sd_q - CW'(1);
	assign sd_m3  = sd_q - CW'(3);
	assign room   = n_q < CW'(MAX_POINTS);
	// sort order test: ccw turn, or farther when collinear
	assign after  = dist_q ? (!stat.geo_zero && !stat.geo_neg) : stat.geo_neg;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		pt_waddr = n_q[IW-1:0];
		pt_raddr = '0;
		so_waddr = '0;
		so_wdata = '0;
		so_raddr = '0;
		st_waddr = '0;
		st_wdata = '0;
		st_raddr = '0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.pt_we = in_valid && room;
				cmd.anc_first = (n_q == '0);
			end
			S_SINIT: begin
				cmd.so_we = 1'b1;
				so_wdata  = anchor_idx;
				cmd.a_sel = cvh_pkg::A_ANC;
			end
			S_SI: pt_raddr = i_q[IW-1:0];
			S_SI_RD: cmd.b_sel = cvh_pkg::B_PT;
			S_SJ: begin
				if (j_q > CW'(1)) begin
					so_raddr = j_dec[IW-1:0];
				end else begin
					cmd.so_we = 1'b1;
					so_waddr  = j_q[IW-1:0];
					so_wdata  = i_q[IW-1:0];
				end
			end
			S_SJ_R1: pt_raddr = so_rdata;
			S_SJ_R2: cmd.c_ld = 1'b1;
			S_GEO1: cmd.geo_dist = dist_q;
			S_SJ_CK: begin
				if (dist_q || !stat.geo_zero) begin
					cmd.so_we = 1'b1;
					so_waddr  = j_q[IW-1:0];
					so_wdata  = after ? c_idx_q : i_q[IW-1:0];
				end
			end
			S_PR_INIT: so_raddr = IW'(1);
			S_PR_R1: pt_raddr = so_rdata;
			S_PR_R2: cmd.b_sel = cvh_pkg::B_PT;
			S_PR_LP: begin
				if (i_inc < n_q) begin
					so_raddr = i_inc[IW-1:0];
				end else begin
					cmd.so_we = 1'b1;
					so_waddr  = kept_q[IW-1:0];
					so_wdata  = b_idx_q;
				end
			end
			S_PR_N1: pt_raddr = so_rdata;
			S_PR_N2: cmd.c_ld = 1'b1;
			S_PR_CK: begin
				cmd.b_sel = cvh_pkg::B_C;
				cmd.so_we = !stat.geo_zero;
				so_waddr  = kept_q[IW-1:0];
				so_wdata  = b_idx_q;
			end
			S_SC_INIT: so_raddr = '0;
			S_SC_0A: begin
				pt_raddr  = so_rdata;
				cmd.st_we = 1'b1;
				st_waddr  = '0;
				st_wdata  = so_rdata;
				so_raddr  = IW'(1);
			end
			S_SC_0B: begin
				cmd.a_sel = cvh_pkg::A_PT;
				pt_raddr  = so_rdata;
				cmd.st_we = 1'b1;
				st_waddr  = IW'(1);
				st_wdata  = so_rdata;
			end
			S_SC_0C: cmd.b_sel = cvh_pkg::B_PT;
			S_SC_LP: so_raddr = i_q[IW-1:0];
			S_SC_R1: pt_raddr = so_rdata;
			S_SC_R2: cmd.c_ld = 1'b1;
			S_SC_CK: begin
				if ((sd_q > CW'(2)) && !stat.geo_neg) begin
					cmd.b_sel = cvh_pkg::B_A;
					st_raddr  = sd_m3[IW-1:0];
				end else begin
					cmd.st_we = 1'b1;
					st_waddr  = sd_q[IW-1:0];
					st_wdata  = c_idx_q;
					cmd.a_sel = cvh_pkg::A_B;
					cmd.b_sel = cvh_pkg::B_C;
				end
			end
			S_SC_P1: pt_raddr = st_rdata;
			S_SC_P2: cmd.a_sel = cvh_pkg::A_PT;
			S_EM_RD: st_raddr = sd_dec[IW-1:0];
			S_EM_R1: begin
				st_raddr = sd_dec[IW-1:0];
				pt_raddr = st_rdata;
			end
			S_EM_R2: begin
				st_raddr     = sd_dec[IW-1:0];
				pt_raddr     = st_rdata;
				cmd.out_load = stat.out_free;
				cmd.out_hv   = 1'b1;
				cmd.out_last = (sd_q == CW'(1));
				cmd.out_ovf  = ovf_q;
			end
			S_EMPTY: begin
				cmd.out_load = stat.out_free;
				cmd.out_last = 1'b1;
				cmd.out_ovf  = ovf_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ret_q   <= S_SJ_CK;
			dist_q  <= 1'b0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			m_q     <= '0;
			kept_q  <= '0;
			sd_q    <= '0;
			a_idx_q <= '0;
			b_idx_q <= '0;
			c_idx_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (room) begin
							n_q <= n_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_point) begin
							state_q <= S_SINIT;
						end
					end
				end
				S_SINIT: begin
					m_q     <= CW'(1);
					i_q     <= '0;
					state_q <= S_SI;
				end
				S_SI: begin
					if (i_q == n_q) begin
						state_q <= S_PR_INIT;
					end else if (i_q[IW-1:0] == anchor_idx) begin
						i_q <= i_inc;
					end else begin
						j_q     <= m_q;
						state_q <= S_SI_RD;
					end
				end
				S_SI_RD: state_q <= S_SJ;
				S_SJ: begin
					if (j_q > CW'(1)) begin
						state_q <= S_SJ_R1;
					end else begin
						m_q     <= m_q + CW'(1);
						i_q     <= i_inc;
						state_q <= S_SI;
					end
				end
				S_SJ_R1: begin
					c_idx_q <= so_rdata;
					state_q <= S_SJ_R2;
				end
				S_SJ_R2: begin
					dist_q  <= 1'b0;
					ret_q   <= S_SJ_CK;
					state_q <= S_GEO1;
				end
				S_GEO1: state_q <= S_GEO2;
				S_GEO2: state_q <= ret_q;
				S_SJ_CK: begin
					if (!dist_q && stat.geo_zero) begin
						dist_q  <= 1'b1;
						state_q <= S_GEO1;
					end else if (after) begin
						j_q     <= j_dec;
						state_q <= S_SJ;
					end else begin
						m_q     <= m_q + CW'(1);
						i_q     <= i_inc;
						state_q <= S_SI;
					end
				end
				S_PR_INIT: begin
					kept_q  <= CW'(1);
					i_q     <= CW'(1);
					state_q <= (n_q > CW'(1)) ? S_PR_R1 : S_EMPTY;
				end
				S_PR_R1: begin
					b_idx_q <= so_rdata;
					state_q <= S_PR_R2;
				end
				S_PR_R2: state_q <= S_PR_LP;
				S_PR_LP: begin
					if (i_inc < n_q) begin
						state_q <= S_PR_N1;
					end else begin
						kept_q  <= kept_q + CW'(1);
						state_q <= S_PR_END;
					end
				end
				S_PR_N1: begin
					c_idx_q <= so_rdata;
					state_q <= S_PR_N2;
				end
				S_PR_N2: begin
					dist_q  <= 1'b0;
					ret_q   <= S_PR_CK;
					state_q <= S_GEO1;
				end
				S_PR_CK: begin
					b_idx_q <= c_idx_q;
					i_q     <= i_inc;
					if (!stat.geo_zero) begin
						kept_q <= kept_q + CW'(1);
					end
					state_q <= S_PR_LP;
				end
				S_PR_END: state_q <= (kept_q < CW'(3)) ? S_EMPTY : S_SC_INIT;
				S_SC_INIT: state_q <= S_SC_0A;
				S_SC_0A: begin
					a_idx_q <= so_rdata;
					state_q <= S_SC_0B;
				end
				S_SC_0B: begin
					b_idx_q <= so_rdata;
					state_q <= S_SC_0C;
				end
				S_SC_0C: begin
					sd_q    <= CW'(2);
					i_q     <= CW'(2);
					state_q <= S_SC_LP;
				end
				S_SC_LP: state_q <= (i_q == kept_q) ? S_EM_RD : S_SC_R1;
				S_SC_R1: begin
					c_idx_q <= so_rdata;
					state_q <= S_SC_R2;
				end
				S_SC_R2: begin
					dist_q  <= 1'b0;
					ret_q   <= S_SC_CK;
					state_q <= S_GEO1;
				end
				S_SC_CK: begin
					if ((sd_q > CW'(2)) && !stat.geo_neg) begin
						sd_q    <= sd_dec;
						b_idx_q <= a_idx_q;
						state_q <= S_SC_P1;
					end else begin
						sd_q    <= sd_q + CW'(1);
						a_idx_q <= b_idx_q;
						b_idx_q <= c_idx_q;
						i_q     <= i_inc;
						state_q <= S_SC_LP;
					end
				end
				S_SC_P1: begin
					a_idx_q <= st_rdata;
					state_q <= S_SC_P2;
				end
				S_SC_P2: state_q <= S_GEO1;
				S_EM_RD: state_q <= S_EM_R1;
				S_EM_R1: state_q <= S_EM_R2;
				S_EM_R2: begin
					if (stat.out_free) begin
						sd_q <= sd_dec;
						if (sd_q == CW'(1)) begin
							n_q     <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_EM_RD;
						end
					end
				end
				S_EMPTY: begin
					if (stat.out_free) begin
						n_q     <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

@@ rtl/core/convex_hull_graham_scan.sv @@
// convex_hull_graham_scan: top level of the graham scan convex hull block
// joins cvh_ctrl (sequencer) and cvh_dp (memories, geometry, output register)
// uses cvh_pkg, cvh_ctrl, cvh_dp, cvh_ram
//
// usage:
//  - input channel (in_valid/in_ready) takes one point item per cycle while
//    loading; last_point = 1 closes the set and starts the hull computation
//  - up to MAX_POINTS points are kept; further points are dropped and every
//    result of that set shows overflowed = 1
//  - output channel (out_valid/out_ready) gives hull vertices from stack top
//    down to the anchor, which carries last_vertex = 1; with fewer than three
//    usable points a single item with hull_valid = 0, zero coordinates and
//    last_vertex = 1 is given instead
//  - in_ready is low from the last point until the final result is loaded in
//    the output register; loading of the next set then starts at once, even
//    while that result still waits to be taken
//  - after the last point, each insertion sort compare step runs an order memory
//    read, point memory read, operand load, two-stage cross-product unit and
//    decision, and the geometry unit runs again as a distance pass when the
//    pair is collinear; pruning, the scan with its pushes and pops, and the
//    emit of each vertex follow, the emit pausing while the receiver stalls
//  - a stalled receiver holds the output register and stops the emit sequencer
//  - reset (arst_n low) empties the point set and the output register
module convex_hull_graham_scan #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] hull_x,
	output logic signed [COORD_BITS-1:0] hull_y,
	output logic                         hull_valid,
	output logic                         overflowed,
	output logic                         last_vertex
);

	localparam int IW = $clog2(MAX_POINTS);

	// sequencer commands and datapath status
	cvh_pkg::cmd_t  cmd;
	cvh_pkg::stat_t stat;

	// memory addresses and index data
	logic [IW-1:0] pt_waddr, pt_raddr;
	logic [IW-1:0] so_waddr, so_wdata, so_raddr, so_rdata;
	logic [IW-1:0] st_waddr, st_wdata, st_raddr, st_rdata;
	logic [IW-1:0] anchor_idx;

	cvh_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_point (last_point),
		.stat       (stat),
		.anchor_idx (anchor_idx),
		.so_rdata   (so_rdata),
		.st_rdata   (st_rdata),
		.cmd        (cmd),
		.pt_waddr   (pt_waddr),
		.pt_raddr   (pt_raddr),
		.so_waddr   (so_waddr),
		.so_wdata   (so_wdata),
		.so_raddr   (so_raddr),
		.st_waddr   (st_waddr),
		.st_wdata   (st_wdata),
		.st_raddr   (st_raddr)
	);

	cvh_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.pt_waddr      (pt_waddr),
		.pt_raddr      (pt_raddr),
		.so_we_dummy_n (1'b1),
		.so_waddr      (so_waddr),
		.so_wdata      (so_wdata),
		.so_raddr      (so_raddr),
		.st_waddr      (st_waddr),
		.st_wdata      (st_wdata),
		.st_raddr      (st_raddr),
		.point_x       (point_x),
		.point_y       (point_y),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.hull_x        (hull_x),
		.hull_y        (hull_y),
		.hull_valid    (hull_valid),
		.overflowed    (overflowed),
		.last_vertex   (last_vertex),
		.stat          (stat),
		.anchor_idx    (anchor_idx),
		.so_rdata      (so_rdata),
		.st_rdata      (st_rdata)
	);

endmodule

@@ rtl/core/cvh_chk.sv @@
// cvh_chk: port-level checker for the convex hull block
// bound to convex_hull_graham_scan; no package dependency
module cvh_chk #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  last_point,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] hull_x,
	input logic [COORD_BITS-1:0] hull_y,
	input logic                  hull_valid,
	input logic                  last_vertex
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hull_x) && $stable(hull_y) &&
			$stable(last_vertex))
		else $error("stalled result changed");

	// empty result closes its set
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hull_valid |-> last_vertex)
		else $error("empty result not marked last");

	// empty result carries zero coordinates
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hull_valid |-> (hull_x == '0) && (hull_y == '0))
		else $error("empty result with nonzero coordinates");

	// closing point stops input until the hull is produced
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_point |=> !in_ready)
		else $error("input taken right after last point");

endmodule

bind convex_hull_graham_scan cvh_chk #(.COORD_BITS(COORD_BITS)) u_cvh_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_point  (last_point),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.hull_x      (hull_x),
	.hull_y      (hull_y),
	.hull_valid  (hull_valid),
	.last_vertex (last_vertex)
);
